// ===== hdl/sgma_pkg.sv =====
// Shared types and constants for the Sobel gradient magnitude/angle block.
// No dependencies; imported by every module of the block except sgma_ram.
`default_nettype none
package sgma_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int POS_W      = 11;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int MAG_W      = 11;
    localparam int CODE_W     = 8;
    localparam int CFG_W      = 11;
    localparam int CORDIC_N   = 30;
    localparam int FIFO_DEPTH = 4;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // one gradient pair handed from the window logic to the math unit
    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic                     last;
    } grad_item_t;

    // arctangent of 2^-i, full circle = 2^32
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/sobel_gradient_magnitude_angle.sv =====
// Top level of the Sobel gradient magnitude/angle block.
// Depends on sgma_pkg, sgma_front, sgma_fifo, sgma_back (and sgma_ram).
//
// Usage:
//  - Input stream (s_*): one grey pixel per transaction in raster order,
//    s_tdata = pixel. s_tuser carries the pixel/drain flag; the position in
//    the frame decides the role, so it is informational. After each frame
//    send frame_width+1 more transactions to flush the last row.
//  - Output stream (m_*): one result per pixel, frame_width+1 input
//    transactions after that pixel; m_tlast marks the frame's final pixel.
//  - Config port: cfg_wr_en/cfg_addr/cfg_wdata, 0 = frame_width,
//    1 = frame_height. A write restarts the frame. Write only when idle.
//  - Flow: the front end takes one transaction, then reads the line store
//    and updates the window before it takes the next. The math unit works
//    on one result at a time (square step, 30 CORDIC iterations, format,
//    output), which sets the sustained rate when results are produced; a
//    4-deep queue decouples the two halves.
//  - Reset (aresetn low, synchronous) clears positions, window, queue and
//    restores 640x480. Line stores are not cleared; they are always written
//    before use.
//  - If m_tready is low the result holds; the queue fills, then s_tready
//    drops until space frees up.
`default_nettype none
module sobel_gradient_magnitude_angle
    import sgma_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] pixel
    input  wire logic              s_tuser,   // [0] operation
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [10:0] grad_x, [21:11] grad_y, [32:22] magnitude,
    // [40:33] direction_code, [47:41] zero
    output logic [47:0]            m_tdata,
    output logic                   m_tlast,   // last_of_frame
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);
    grad_item_t               push_item, pop_item;
    logic                     push, pop, fifo_full, fifo_empty;
    logic signed [GRAD_W-1:0] grad_x, grad_y;
    logic [MAG_W-1:0]         magnitude;
    logic [CODE_W-1:0]        direction_code;

    sgma_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .pixel(s_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .push(push), .push_item(push_item), .fifo_full(fifo_full)
    );

    sgma_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_item(push_item), .full(fifo_full),
        .pop(pop), .pop_item(pop_item), .empty(fifo_empty)
    );

    sgma_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .fifo_empty(fifo_empty), .pop_item(pop_item), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .grad_x(grad_x), .grad_y(grad_y), .magnitude(magnitude),
        .direction_code(direction_code), .last_of_frame(m_tlast)
    );

    assign m_tdata = {7'b0, direction_code, magnitude, grad_y, grad_x};
endmodule
`default_nettype wire

// ===== hdl/sgma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sgma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/sgma_front.sv =====
// Front end: frame position tracking, line stores, 3x3 window, gradients.
// Depends on sgma_pkg and sgma_ram.
`default_nettype none
module sgma_front
    import sgma_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [PIX_W-1:0]  pixel,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    output logic                   push,
    output grad_item_t             push_item,
    input  wire logic              fifo_full
);
    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_PROC = 2'b10
    } front_state_t;

    front_state_t     state_reg, state_next;
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [POS_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [POS_W-1:0] r_reg, c_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] win_reg [3][3];
    logic [PIX_W-1:0] win_next [3][3];
    logic [PIX_W-1:0] sel [3][3];
    logic [PIX_W-1:0] upper_q, lower_q, top, mid, bot, v;
    logic [POS_W-1:0] w_eff, h_eff, r_acc, c_acc, c_inc;
    logic             accept, emit0, emit1, last_row, done, ram_we;
    logic [9:0]       sum_l, sum_r, sum_t, sum_b;

    assign w_eff = (width_reg == '0) ? POS_W'(1) :
                   (width_reg > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? POS_W'(1) :
                   (height_reg > POS_W'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT) : height_reg;

    assign s_tready = (state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;

    // out-of-range position restarts the frame
    always_comb begin
        if (col_reg >= w_eff || row_reg > h_eff + POS_W'(1)) begin
            r_acc = '0;
            c_acc = '0;
        end else begin
            r_acc = row_reg;
            c_acc = col_reg;
        end
    end

    sgma_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .aclk(aclk), .we(ram_we), .waddr(c_reg[ADDR_W-1:0]), .wdata(mid),
        .raddr(c_acc[ADDR_W-1:0]), .rdata(upper_q)
    );
    sgma_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .aclk(aclk), .we(ram_we), .waddr(c_reg[ADDR_W-1:0]), .wdata(bot),
        .raddr(c_acc[ADDR_W-1:0]), .rdata(lower_q)
    );

    assign last_row = (r_reg == h_eff + POS_W'(1));
    assign emit0    = (c_reg == '0) && (r_reg >= POS_W'(2));
    assign emit1    = !last_row && (r_reg >= POS_W'(1)) && (c_reg != '0);
    assign mid      = lower_q;
    assign top      = (r_reg >= POS_W'(2)) ? upper_q : mid;
    assign bot      = (r_reg < h_eff) ? pix_reg : mid;
    assign done     = (state_reg == F_PROC) && !((emit0 || emit1) && fifo_full);
    assign ram_we   = done && !last_row;
    assign c_inc    = c_reg + POS_W'(1);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v = (i == 0) ? top : (i == 1) ? mid : bot;
            win_next[i][0] = (c_reg == '0) ? v : win_reg[i][1];
            win_next[i][1] = (c_reg == '0) ? v : win_reg[i][2];
            win_next[i][2] = v;
            // start of a row: finish the previous row with the right edge copied
            if (emit0) begin
                sel[i][0] = win_reg[i][1];
                sel[i][1] = win_reg[i][2];
                sel[i][2] = win_reg[i][2];
            end else begin
                sel[i] = win_next[i];
            end
        end
        sum_l = {2'b0, sel[0][0]} + {1'b0, sel[1][0], 1'b0} + {2'b0, sel[2][0]};
        sum_r = {2'b0, sel[0][2]} + {1'b0, sel[1][2], 1'b0} + {2'b0, sel[2][2]};
        sum_t = {2'b0, sel[0][0]} + {1'b0, sel[0][1], 1'b0} + {2'b0, sel[0][2]};
        sum_b = {2'b0, sel[2][0]} + {1'b0, sel[2][1], 1'b0} + {2'b0, sel[2][2]};
    end

    assign push             = done && (emit0 || emit1);
    assign push_item.grad_x = GRAD_W'({1'b0, sum_r} - {1'b0, sum_l});
    assign push_item.grad_y = GRAD_W'({1'b0, sum_b} - {1'b0, sum_t});
    assign push_item.last   = emit0 && last_row;

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_PROC;
                end
            end
            F_PROC: begin
                if (done) begin
                    state_next = F_IDLE;
                    if (last_row) begin
                        row_next = '0;
                        col_next = '0;
                    end else if (c_inc == w_eff) begin
                        row_next = r_reg + POS_W'(1);
                        col_next = '0;
                    end else begin
                        row_next = r_reg;
                        col_next = c_inc;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
        if (cfg_wr_en) begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
            row_reg    <= '0;
            col_reg    <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                    CFG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (ram_we) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            r_reg   <= r_acc;
            c_reg   <= c_acc;
            pix_reg <= pixel;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/sgma_fifo.sv =====
// Short queue of gradient pairs between the window logic and the math unit.
// Depends on sgma_pkg.
`default_nettype none
module sgma_fifo
    import sgma_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  grad_item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output grad_item_t pop_item,
    output logic       empty
);
    localparam int PW = $clog2(FIFO_DEPTH);

    grad_item_t    mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign full     = (cnt_reg == (PW+1)'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push && !full) begin
                wp_reg <= wp_reg + PW'(1);
            end
            if (pop && !empty) begin
                rp_reg <= rp_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wp_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/sgma_back.sv =====
// Back end: iterative square root and CORDIC angle, result register.
// Depends on sgma_pkg.
`default_nettype none
module sgma_back
    import sgma_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fifo_empty,
    input  grad_item_t              pop_item,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic signed [GRAD_W-1:0] grad_x,
    output logic signed [GRAD_W-1:0] grad_y,
    output logic [MAG_W-1:0]        magnitude,
    output logic [CODE_W-1:0]       direction_code,
    output logic                    last_of_frame
);
    localparam int XW = 38;
    localparam int SW = 22;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_SQ   = 5'b00010,
        B_RUN  = 5'b00100,
        B_FIN  = 5'b01000,
        B_OUT  = 5'b10000
    } back_state_t;

    back_state_t           state_reg;
    grad_item_t            it_reg;
    logic [SW-1:0]         sqx_reg, sqy_reg;
    logic [SW-1:0]         v_reg, res_reg, bit_reg;
    logic signed [XW-1:0]  x_reg, y_reg, xs, ys, gxw, gyw;
    logic [31:0]           z_reg;
    logic [4:0]            i_reg;
    logic                  special_reg;
    logic [39:0]           prod;
    logic [SW-1:0]         trial;

    function automatic logic signed [XW-1:0] stz(input logic signed [XW-1:0] a,
                                                  input logic [4:0] s);
        logic [XW-1:0] m;
        m = a[XW-1] ? XW'(-a) : a;
        m = m >> s;
        return a[XW-1] ? -$signed(m) : $signed(m);
    endfunction

    assign pop      = (state_reg == B_IDLE) && !fifo_empty;
    assign m_tvalid = (state_reg == B_OUT);
    assign xs       = stz(y_reg, i_reg);
    assign ys       = stz(x_reg, i_reg);
    assign gxw      = {{(XW-GRAD_W-24){it_reg.grad_x[GRAD_W-1]}}, it_reg.grad_x, 24'b0};
    assign gyw      = {{(XW-GRAD_W-24){it_reg.grad_y[GRAD_W-1]}}, it_reg.grad_y, 24'b0};
    assign trial    = res_reg + bit_reg;
    // z*255 + 2^31, code is the top byte
    assign prod     = ({z_reg, 8'b0} - {8'b0, z_reg}) + 40'h0080000000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            unique case (state_reg)
                B_IDLE: if (!fifo_empty) state_reg <= B_SQ;
                B_SQ:   state_reg <= B_RUN;
                B_RUN:  if (i_reg == 5'(CORDIC_N-1)) state_reg <= B_FIN;
                B_FIN:  state_reg <= B_OUT;
                B_OUT:  if (m_tready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                it_reg  <= pop_item;
                sqx_reg <= SW'($signed(pop_item.grad_x) * $signed(pop_item.grad_x));
                sqy_reg <= SW'($signed(pop_item.grad_y) * $signed(pop_item.grad_y));
            end
            B_SQ: begin
                v_reg       <= sqx_reg + sqy_reg;
                res_reg     <= '0;
                bit_reg     <= SW'(1) << 20;
                i_reg       <= '0;
                special_reg <= (it_reg.grad_y == '0);
                if (it_reg.grad_x[GRAD_W-1]) begin
                    x_reg <= -gxw;
                    y_reg <= -gyw;
                    z_reg <= 32'h80000000;
                end else begin
                    x_reg <= gxw;
                    y_reg <= gyw;
                    z_reg <= '0;
                end
            end
            B_RUN: begin
                i_reg <= i_reg + 5'd1;
                if (bit_reg != '0) begin
                    if (v_reg >= trial) begin
                        v_reg   <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                if (y_reg > 0) begin
                    x_reg <= x_reg + xs;
                    y_reg <= y_reg - ys;
                    z_reg <= z_reg + atan_lut(i_reg);
                end else begin
                    x_reg <= x_reg - xs;
                    y_reg <= y_reg + ys;
                    z_reg <= z_reg - atan_lut(i_reg);
                end
            end
            B_FIN: begin
                grad_x        <= it_reg.grad_x;
                grad_y        <= it_reg.grad_y;
                magnitude     <= res_reg[MAG_W-1:0];
                last_of_frame <= it_reg.last;
                if (special_reg) begin
                    direction_code <= it_reg.grad_x[GRAD_W-1] ? CODE_W'(128) : '0;
                end else begin
                    direction_code <= prod[39:32];
                end
            end
            B_OUT: ;
            default: ;
        endcase
    end
endmodule
`default_nettype wire
